### hw/rtl/polyline_simplify_vertical_macros.svh
// assertion macros for the vertical polyline simplifier
// used by the top level only; define NO_ASSERTIONS to drop them
`ifndef POLYLINE_SIMPLIFY_VERTICAL_MACROS_SVH
`define POLYLINE_SIMPLIFY_VERTICAL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSV_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PSV_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PSV_ASSERT_IMPL(label, clk, rst_n, a, c)
`define PSV_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/psv_pkg.sv
// shared types and constants of the vertical polyline simplifier
// no dependencies
package psv_pkg;
  localparam int MaxPointsDefault = 64;
  localparam int MaxResults = 64;
  localparam int TimeW = 32;
  localparam int ValueW = 16;
  localparam int TolW = 16;
  localparam int IndexW = 6;
  localparam logic [0:0] RegTolerance = 1'b0;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEED, ST_POP, ST_RDHI, ST_HDR, ST_SCAN, ST_MUL, ST_CMP,
    ST_DEC, ST_PUSH2, ST_EMIT, ST_CLEAR
  } state_t;
endpackage

### hw/rtl/psv_dev.sv
// deviation unit: two pipeline registers from a stored point to |D|
// depends on psv_pkg
module psv_dev (
  input  logic                                   clk,
  input  logic                                   mode_abs,
  input  logic signed [psv_pkg::TimeW:0]         dt,
  input  logic signed [psv_pkg::ValueW:0]        dv,
  input  logic signed [psv_pkg::ValueW-1:0]      va,
  input  logic [psv_pkg::TimeW-1:0]              t_lo,
  input  logic [psv_pkg::TimeW-1:0]              t_i,
  input  logic signed [psv_pkg::ValueW-1:0]      v_i,
  output logic [65:0]                            dev
);
  import psv_pkg::*;
  logic signed [ValueW:0] dvi;
  logic signed [TimeW:0] dtp;
  logic signed [65:0] p1_r, p2_r, dabs_r, diff;
  logic signed [ValueW:0] dvi_r;
  logic mode_r;

  assign dvi = $signed({v_i[ValueW-1], v_i}) - $signed({va[ValueW-1], va});
  assign dtp = $signed({1'b0, t_i}) - $signed({1'b0, t_lo});

  // first stage: two products, second: difference and abs
  always_ff @(posedge clk) begin
    p1_r <= 66'(dvi * dt);
    p2_r <= 66'(dtp * dv);
    dvi_r <= dvi;
    mode_r <= mode_abs;
  end

  always_comb begin
    if (mode_r) begin
      diff = 66'(dvi_r);
    end else begin
      diff = p1_r - p2_r;
    end
  end

  always_ff @(posedge clk) begin
    dabs_r <= diff[65] ? -diff : diff;
  end

  assign dev = dabs_r;
endmodule

### hw/rtl/polyline_simplify_vertical.sv
// vertical polyline simplifier: point load, stack based split search, index output
// depends on psv_pkg, psv_dev and polyline_simplify_vertical_macros.svh
// Points load one per cycle, while in_ready is high, into on-chip memories; a point
// carrying in_last_point starts simplification, during which in_ready is low. Each
// range popped from the work stack has its endpoints fetched and its interior points
// streamed through the single memory read port and a two-stage deviation unit;
// a range that splits pushes both halves, one with no interior point is skipped.
// The keep marks are then scanned index by index up to the last kept one, each kept
// index leaving as one word, and output stalls hold the scan. A clearing sweep over
// all MAX_POINTS keep marks follows, and also runs after reset, before the next curve
// is accepted.
`include "polyline_simplify_vertical_macros.svh"
module polyline_simplify_vertical #(
  parameter int MAX_POINTS = psv_pkg::MaxPointsDefault
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [psv_pkg::TimeW-1:0]          in_point_time,
  input  logic signed [psv_pkg::ValueW-1:0]  in_point_value,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [psv_pkg::IndexW-1:0]         out_kept_index,
  output logic                               out_last_kept,
  output logic                               out_overflow,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import psv_pkg::*;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int ResW = $clog2(MaxResults + 1);

  logic [TimeW-1:0] tmem [MAX_POINTS];
  logic [ValueW-1:0] vmem [MAX_POINTS];
  logic [2*AW-1:0] smem [MAX_POINTS];
  logic keep_mem [MAX_POINTS];

  state_t state_r, state_nxt;
  logic [TolW-1:0] tol_r;
  logic [CW-1:0] cnt_r, cnt_nxt, sp_r, sp_nxt;
  logic ovf_r, ovf_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, best_r, best_nxt, idx_r, idx_nxt;
  logic [TimeW-1:0] tlo_r, tlo_nxt;
  logic signed [ValueW-1:0] vlo_r, vlo_nxt;
  logic signed [TimeW:0] dt_r, dt_nxt;
  logic signed [ValueW:0] dv_r, dv_nxt;
  logic [65:0] bestd_r, bestd_nxt;
  logic [AW-1:0] ridx_r, ridx_nxt;
  logic [2:0] vld_r, vld_nxt;
  logic [AW-1:0] pidx1_r, pidx2_r, pidx3_r;
  logic [ResW-1:0] emit_r, emit_nxt, total_r, total_nxt;

  // memory ports
  logic [AW-1:0] rd_addr;
  logic [TimeW-1:0] t_rd_r;
  logic [ValueW-1:0] v_rd_r;
  logic [2*AW-1:0] s_rd_r;
  logic k_rd_r;
  logic s_we, k_we, k_wd, p_we;
  logic [AW-1:0] s_wa, k_wa, p_wa;
  logic [2*AW-1:0] s_wd;
  logic [AW-1:0] k_ra;
  logic [65:0] dev;
  logic out_v_r, out_v_nxt;
  logic [IndexW-1:0] out_i_r, out_i_nxt;
  logic out_l_r, out_l_nxt;
  logic [65:0] limit;
  logic n_small;

  always_ff @(posedge clk) begin
    if (p_we) begin
      tmem[p_wa] <= in_point_time;
      vmem[p_wa] <= in_point_value;
    end
    t_rd_r <= tmem[rd_addr];
    v_rd_r <= vmem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_rd_r <= smem[sp_r[AW-1:0] - AW'(1)];
  end
  always_ff @(posedge clk) begin
    if (k_we) keep_mem[k_wa] <= k_wd;
    k_rd_r <= keep_mem[k_ra];
  end

  psv_dev u_dev (
    .clk(clk), .mode_abs(dt_r <= 0), .dt(dt_r), .dv(dv_r), .va(vlo_r),
    .t_lo(tlo_r), .t_i(t_rd_r), .v_i(v_rd_r), .dev(dev)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegTolerance) ? {16'b0, tol_r} : 32'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == RegTolerance)
      tol_r <= cfg_pwdata[TolW-1:0];
  end

  assign in_ready = (state_r == ST_LOAD);
  assign out_valid = out_v_r;
  assign out_kept_index = out_i_r;
  assign out_last_kept = out_l_r;
  assign out_overflow = ovf_r;
  assign limit = (dt_r <= 0) ? 66'(tol_r) : 66'($unsigned(tol_r) * dt_r[TimeW-1:0]);
  assign n_small = (cnt_r <= CW'(2));

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; sp_nxt = sp_r; ovf_nxt = ovf_r;
    lo_nxt = lo_r; hi_nxt = hi_r; best_nxt = best_r; idx_nxt = idx_r;
    tlo_nxt = tlo_r; vlo_nxt = vlo_r; dt_nxt = dt_r; dv_nxt = dv_r;
    bestd_nxt = bestd_r; ridx_nxt = ridx_r; vld_nxt = {vld_r[1:0], 1'b0};
    emit_nxt = emit_r; total_nxt = total_r;
    out_v_nxt = out_v_r; out_i_nxt = out_i_r; out_l_nxt = out_l_r;
    rd_addr = ridx_r; p_we = 1'b0; p_wa = cnt_r[AW-1:0];
    s_we = 1'b0; s_wa = sp_r[AW-1:0]; s_wd = {lo_r, hi_r};
    k_we = 1'b0; k_wa = idx_r; k_wd = 1'b1; k_ra = idx_r;
    if (out_v_r && out_ready) out_v_nxt = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            p_we = 1'b1; cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_point) state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        // endpoints kept; count kept points as they are marked
        total_nxt = ResW'(cnt_r > CW'(MaxResults) ? MaxResults : cnt_r);
        if (n_small) begin
          k_we = (cnt_r != '0); k_wa = '0;
          idx_nxt = (cnt_r == CW'(2)) ? AW'(1) : '0;
          state_nxt = (cnt_r == CW'(2)) ? ST_PUSH2 : ST_EMIT;
          total_nxt = ResW'(cnt_r);
          hi_nxt = '1;
        end else begin
          k_we = 1'b1; k_wa = '0;
          s_we = 1'b1; s_wa = '0; s_wd = {AW'(0), AW'(cnt_r - CW'(1))};
          sp_nxt = CW'(1); total_nxt = ResW'(2);
          idx_nxt = AW'(cnt_r - CW'(1));
          state_nxt = ST_PUSH2;
          hi_nxt = '0;
        end
      end
      ST_PUSH2: begin
        // second endpoint mark, reused to mark best and its push
        k_we = 1'b1; k_wa = idx_r;
        if (hi_r == '1) begin
          idx_nxt = '0; state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          idx_nxt = '0; state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RDHI;
        end
      end
      ST_RDHI: begin
        lo_nxt = s_rd_r[2*AW-1:AW]; hi_nxt = s_rd_r[AW-1:0];
        sp_nxt = sp_r - CW'(1);
        if ({1'b0, s_rd_r[AW-1:0]} <= {1'b0, s_rd_r[2*AW-1:AW]} + (AW+1)'(1)) begin
          state_nxt = ST_POP;
        end else begin
          rd_addr = s_rd_r[2*AW-1:AW];
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        // t_rd_r/v_rd_r hold lo; fetch hi next
        if (!vld_r[0]) begin
          tlo_nxt = t_rd_r; vlo_nxt = v_rd_r;
          rd_addr = hi_r; vld_nxt = 3'b001;
        end else begin
          dt_nxt = $signed({1'b0, t_rd_r}) - $signed({1'b0, tlo_r});
          dv_nxt = $signed({v_rd_r[ValueW-1], v_rd_r}) - $signed({vlo_r[ValueW-1], vlo_r});
          rd_addr = lo_r + AW'(1); ridx_nxt = lo_r + AW'(2);
          bestd_nxt = '0; best_nxt = lo_r; vld_nxt = 3'b001;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // one interior point per cycle, vld_r tracks the pipe
        if ({1'b0, ridx_r} < {1'b0, hi_r} && ridx_r != '0) begin
          rd_addr = ridx_r; ridx_nxt = ridx_r + AW'(1); vld_nxt[0] = 1'b1;
        end else begin
          ridx_nxt = '0;
        end
        if (vld_r[2] && dev > bestd_r) begin
          bestd_nxt = dev; best_nxt = pidx3_r;
        end
        if (vld_nxt == '0) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (bestd_r > limit) begin
          s_we = 1'b1; s_wa = sp_r[AW-1:0]; s_wd = {lo_r, best_r};
          sp_nxt = sp_r + CW'(1); state_nxt = ST_DEC;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_DEC: begin
        s_we = 1'b1; s_wa = sp_r[AW-1:0]; s_wd = {best_r, hi_r};
        sp_nxt = sp_r + CW'(1); idx_nxt = best_r; hi_nxt = '0;
        if (total_r < ResW'(MaxResults)) total_nxt = total_r + ResW'(1);
        state_nxt = ST_PUSH2;
      end
      ST_EMIT: begin
        // keep_mem read is registered; ridx_r holds the index being read
        k_ra = idx_r;
        if (!vld_r[0]) begin
          vld_nxt = 3'b001; ridx_nxt = idx_r; idx_nxt = idx_r + AW'(1);
        end else if (!out_v_r || out_ready) begin
          vld_nxt = 3'b000;
          if (k_rd_r && emit_r < total_r) begin
            out_v_nxt = 1'b1; out_i_nxt = IndexW'(ridx_r);
            out_l_nxt = (emit_r + ResW'(1) == total_r);
            emit_nxt = emit_r + ResW'(1);
          end
          if ({1'b0, ridx_r} + CW'(1) >= cnt_r || emit_r >= total_r) begin
            idx_nxt = '0; state_nxt = ST_CLEAR;
          end
        end else begin
          vld_nxt = 3'b001;
          idx_nxt = idx_r; k_ra = ridx_r; idx_nxt = ridx_r + AW'(1);
        end
      end
      ST_CLEAR: begin
        k_we = 1'b1; k_wa = idx_r; k_wd = 1'b0; idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(MAX_POINTS - 1) && !out_v_nxt) begin
          state_nxt = ST_LOAD; cnt_nxt = '0; ovf_nxt = 1'b0; sp_nxt = '0;
          emit_nxt = '0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    pidx1_r <= rd_addr; pidx2_r <= pidx1_r; pidx3_r <= pidx2_r;
    lo_r <= lo_nxt; hi_r <= hi_nxt; best_r <= best_nxt;
    tlo_r <= tlo_nxt; vlo_r <= vlo_nxt; dt_r <= dt_nxt; dv_r <= dv_nxt;
    bestd_r <= bestd_nxt; ridx_r <= ridx_nxt;
    out_i_r <= out_i_nxt; out_l_r <= out_l_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; cnt_r <= '0; sp_r <= '0; ovf_r <= 1'b0;
      vld_r <= '0; emit_r <= '0; out_v_r <= 1'b0; idx_r <= '0; total_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; sp_r <= sp_nxt; ovf_r <= ovf_nxt;
      vld_r <= vld_nxt; emit_r <= emit_nxt; out_v_r <= out_v_nxt;
      idx_r <= idx_nxt; total_r <= total_nxt;
    end
  end

  `PSV_ASSERT_IMPL(a_sp_bound, clk, rst_n, 1'b1, sp_r <= CW'(MAX_POINTS))
  `PSV_ASSERT_IMPL(a_no_load_busy, clk, rst_n, state_r != ST_LOAD, !in_ready)
  `PSV_ASSERT_IMPL(a_emit_bound, clk, rst_n, 1'b1, emit_r <= total_r || state_r == ST_LOAD)
  `PSV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
